FILE: rtl/core/msui_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and log2/log10 helpers for the SUI path loss block.
package msui_pkg;

  localparam int DIST_W     = 20;
  localparam int LOSS_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int MANT_W     = 31;
  localparam int FRAC_W     = 16;
  localparam int MSB_W      = 5;
  localparam int LG_W       = 20;
  localparam int DIV_W      = 48;
  localparam int DEN_W      = 32;
  localparam int CNT_W      = 6;
  localparam int GAM_W      = 25;
  localparam int G10_W      = 29;
  localparam int P_W        = 24;
  localparam int K_W        = 32;
  localparam int NSQ        = FRAC_W;
  localparam int NST        = NSQ + 5;

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;

  localparam logic signed [K_W-1:0] PLF_OFS    = 32'sd1298018;
  localparam logic signed [K_W-1:0] ATT_OFS    = 32'sd920854;
  localparam logic signed [K_W-1:0] OKU_LO_OFS = 32'sd968046;
  localparam logic signed [K_W-1:0] OKU_HI_OFS = 32'sd1936092;
  localparam logic signed [K_W-1:0] FS_CONST   = 32'sd3116776;
  localparam logic signed [K_W-1:0] FS_D0_OFS  = 32'sd815384;
  localparam logic signed [LG_W:0]  D0_LOG     = 21'sd196608;

  localparam logic [7:0]  OKU_HR_SPLIT = 8'd30;
  localparam logic [16:0] HT_SCALE     = 17'd100000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERRAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TX_HT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RX_HT   = 3'd4;

  localparam logic [1:0] TERR_A = 2'd0;
  localparam logic [1:0] TERR_B = 2'd1;

  localparam logic [1:0] MODE_ATT = 2'd1;
  localparam logic [1:0] MODE_OKU = 2'd2;

  typedef enum logic [4:0] {
    ES_LF_INIT, ES_LF_SQ, ES_LF_MUL,
    ES_LH_INIT, ES_LH_SQ, ES_LH_MUL,
    ES_HT2, ES_NUM1, ES_NUM2,
    ES_GSTART, ES_GDIV, ES_GAMMA,
    ES_P,
    ES_QSTART, ES_QDIV, ES_FIN, ES_DONE
  } eng_state_t;

  typedef struct packed {
    logic                    ok;
    logic [G10_W-1:0]        g10;
    logic signed [P_W-1:0]   p;
    logic signed [K_W-1:0]   kb;
    logic signed [K_W-1:0]   kf;
  } coef_t;

  function automatic logic [MSB_W-1:0] msb_idx(input logic [DIST_W-1:0] x);
    logic [MSB_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIST_W; i++) begin
      if (x[i]) n = MSB_W'(i);
    end
    return n;
  endfunction

  // mantissa with its leading one at bit 30
  function automatic logic [MANT_W-1:0] lg_norm(input logic [DIST_W-1:0] x,
                                                input logic [MSB_W-1:0] n);
    logic [MANT_W-1:0] w;
    w = MANT_W'(x);
    return w << (MSB_W'(MANT_W - 1) - n);
  endfunction

  // one squaring step: {fraction bit, renormalized mantissa}
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    sq = m * m;
    t  = sq[MANT_W+30:30];
    return t[MANT_W] ? {1'b1, t[MANT_W:1]} : {1'b0, t[MANT_W-1:0]};
  endfunction

  function automatic logic [LG_W-1:0] lg10_q16(input logic [MSB_W-1:0] n,
                                               input logic [FRAC_W-1:0] frac);
    logic [MSB_W+FRAC_W+30:0] pr;
    pr = {n, frac} * LOG10_2_Q32;
    return pr[LG_W+31:32];
  endfunction

  function automatic logic [18:0] terr_a10(input logic [1:0] t);
    logic [18:0] v;
    unique case (t)
      TERR_A:  v = 19'd460000;
      TERR_B:  v = 19'd400000;
      default: v = 19'd360000;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] terr_b4(input logic [1:0] t);
    logic [6:0] v;
    unique case (t)
      TERR_A:  v = 7'd75;
      TERR_B:  v = 7'd65;
      default: v = 7'd50;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] terr_c100(input logic [1:0] t);
    logic [24:0] v;
    unique case (t)
      TERR_A:  v = 25'd12600000;
      TERR_B:  v = 25'd17100000;
      default: v = 25'd20000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/msui_coef_eng.sv
`timescale 1ns / 1ps
// Configuration registers and sequential engine for the per-config coefficients.
module msui_coef_eng (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [msui_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msui_pkg::CFG_DATA_W-1:0]     cfg_data,
  output msui_pkg::coef_t                     coef
);

  localparam int KW    = msui_pkg::K_W;
  localparam int DW    = msui_pkg::DIV_W;
  localparam int DNW   = msui_pkg::DEN_W;
  localparam int LW    = msui_pkg::LG_W;
  localparam int GW    = msui_pkg::GAM_W;
  localparam int PW    = msui_pkg::P_W;
  localparam int FW    = msui_pkg::FRAC_W;
  localparam int MW    = msui_pkg::MANT_W;
  localparam int CW    = msui_pkg::CNT_W;
  localparam int DSTW  = msui_pkg::DIST_W;
  localparam logic [CW-1:0] SQ_LAST  = CW'(FW - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  // ceil(2^35 / 10): x / 10 = (x * RCP10) >> 35, exact for x below 2^32
  localparam logic [31:0]   RCP10    = 32'hCCCCCCCD;

  typedef struct packed {
    logic lg_load;
    logic lg_step;
    logic div_load;
    logic div_step;
    logic ok;
  } eng_ctl_t;

  logic [1:0]  terrain_r;
  logic [1:0]  mode_r;
  logic [13:0] carrier_r;
  logic [9:0]  tx_r;
  logic [7:0]  rx_r;

  msui_pkg::eng_state_t state_r, state_nxt;
  eng_ctl_t             ctl;
  logic [CW-1:0]        cnt_r;

  logic [13:0] f_eff;
  logic [9:0]  ht_eff;
  logic [7:0]  hr_eff;

  assign f_eff  = (carrier_r == '0) ? 14'd1 : carrier_r;
  assign ht_eff = (tx_r == '0) ? 10'd1 : tx_r;
  assign hr_eff = (rx_r == '0) ? 8'd1 : rx_r;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terrain_r <= 2'd0;
      mode_r    <= 2'd0;
      carrier_r <= 14'd2000;
      tx_r      <= 10'd300;
      rx_r      <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msui_pkg::REG_TERRAIN: terrain_r <= cfg_data[1:0];
        msui_pkg::REG_MODE:    mode_r    <= cfg_data[1:0];
        msui_pkg::REG_CARRIER: carrier_r <= cfg_data;
        msui_pkg::REG_TX_HT:   tx_r      <= cfg_data[9:0];
        msui_pkg::REG_RX_HT:   rx_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = msui_pkg::ES_LF_INIT;
    end else begin
      unique case (state_r)
        msui_pkg::ES_LF_INIT: state_nxt = msui_pkg::ES_LF_SQ;
        msui_pkg::ES_LF_SQ:   if (cnt_r == SQ_LAST) state_nxt = msui_pkg::ES_LF_MUL;
        msui_pkg::ES_LF_MUL:  state_nxt = msui_pkg::ES_LH_INIT;
        msui_pkg::ES_LH_INIT: state_nxt = msui_pkg::ES_LH_SQ;
        msui_pkg::ES_LH_SQ:   if (cnt_r == SQ_LAST) state_nxt = msui_pkg::ES_LH_MUL;
        msui_pkg::ES_LH_MUL:  state_nxt = msui_pkg::ES_HT2;
        msui_pkg::ES_HT2:     state_nxt = msui_pkg::ES_NUM1;
        msui_pkg::ES_NUM1:    state_nxt = msui_pkg::ES_NUM2;
        msui_pkg::ES_NUM2:    state_nxt = msui_pkg::ES_GSTART;
        msui_pkg::ES_GSTART:  state_nxt = msui_pkg::ES_GDIV;
        msui_pkg::ES_GDIV:    if (cnt_r == DIV_LAST) state_nxt = msui_pkg::ES_GAMMA;
        msui_pkg::ES_GAMMA:   state_nxt = msui_pkg::ES_P;
        msui_pkg::ES_P:       state_nxt = msui_pkg::ES_QSTART;
        msui_pkg::ES_QSTART:  state_nxt = msui_pkg::ES_QDIV;
        msui_pkg::ES_QDIV:    if (cnt_r == DIV_LAST) state_nxt = msui_pkg::ES_FIN;
        msui_pkg::ES_FIN:     state_nxt = msui_pkg::ES_DONE;
        msui_pkg::ES_DONE:    state_nxt = msui_pkg::ES_DONE;
        default:              state_nxt = msui_pkg::ES_LF_INIT;
      endcase
    end
  end

  // control outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      msui_pkg::ES_LF_INIT, msui_pkg::ES_LH_INIT: ctl.lg_load = 1'b1;
      msui_pkg::ES_LF_SQ, msui_pkg::ES_LH_SQ:     ctl.lg_step = 1'b1;
      msui_pkg::ES_GSTART, msui_pkg::ES_QSTART:   ctl.div_load = 1'b1;
      msui_pkg::ES_GDIV, msui_pkg::ES_QDIV:       ctl.div_step = 1'b1;
      msui_pkg::ES_DONE: ctl.ok = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msui_pkg::ES_LF_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.lg_load || ctl.div_load) begin
        cnt_r <= '0;
      end else if (ctl.lg_step || ctl.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // serial log unit
  logic [DSTW-1:0]              lg_x;
  logic [msui_pkg::MSB_W-1:0]   lg_n0;
  logic [msui_pkg::MSB_W-1:0]   lg_n_r;
  logic [MW-1:0]                lg_m_r;
  logic [FW-1:0]                lg_frac_r;
  logic [MW:0]                  lg_sq;
  logic [LW-1:0]                lg10_c;

  assign lg_x   = (state_r == msui_pkg::ES_LF_INIT) ? DSTW'(f_eff) : DSTW'(hr_eff);
  assign lg_n0  = msui_pkg::msb_idx(lg_x);
  assign lg_sq  = msui_pkg::sq_step(lg_m_r);
  assign lg10_c = msui_pkg::lg10_q16(lg_n_r, lg_frac_r);

  // serial restoring divider, signed numerator, positive divisor
  logic signed [DW:0] div_num, div_neg_num, div_res;
  logic [DNW-1:0]     div_den;
  logic [DW-1:0]      dq_r;
  logic [DNW-1:0]     drem_r, dden_r;
  logic               dneg_r;
  logic [DNW:0]       div_t, div_sub;
  logic               div_ge;

  logic [LW-1:0]           lf_r, lh_r;
  logic [19:0]             ht2_r;
  logic signed [39:0]      num_r;
  logic [GW-1:0]           gamma_r;
  logic signed [PW-1:0]    p_r;
  logic [msui_pkg::G10_W-1:0] g10_r;
  logic signed [KW-1:0]    kb_r, kf_r;

  logic [28:0] a_ht;
  logic [29:0] num1;
  logic [26:0] b_ht2;
  logic [26:0] den_g;
  logic [26:0] lh108;
  logic [58:0] lh_rcp;
  logic [23:0] lh_q10;

  assign a_ht  = msui_pkg::terr_a10(terrain_r) * ht_eff;
  assign num1  = {1'b0, a_ht} + {5'b0, msui_pkg::terr_c100(terrain_r)};
  assign b_ht2 = msui_pkg::terr_b4(terrain_r) * ht2_r;
  assign den_g = msui_pkg::HT_SCALE * ht_eff;
  assign lh108 = {1'b0, lh_r, 6'b0} + {2'b0, lh_r, 5'b0} + {4'b0, lh_r, 3'b0}
               + {5'b0, lh_r, 2'b0};
  // 108*lg10(hr) / 10 by reciprocal multiply
  assign lh_rcp = lh108 * RCP10;
  assign lh_q10 = lh_rcp[58:35];

  always_comb begin
    div_num = '0;
    div_den = DNW'(1);
    unique case (state_r)
      msui_pkg::ES_GSTART: begin
        div_num = $signed({num_r[DW-16:0], 16'b0});
        div_den = DNW'(den_g);
      end
      msui_pkg::ES_QSTART: begin
        div_num = $signed({{(DW+1-PW-17){p_r[PW-1]}}, p_r, 17'b0});
        div_den = DNW'(gamma_r);
      end
      default: ;
    endcase
  end

  assign div_neg_num = -div_num;
  assign div_t       = {drem_r, dq_r[DW-1]};
  assign div_sub     = div_t - {1'b0, dden_r};
  assign div_ge      = (div_t >= {1'b0, dden_r});
  assign div_res     = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  // arithmetic on the stored logs
  logic signed [KW-1:0] lf_s, lh_s, q_s, lf6, lf20, lh10, lh20, lh_att, p_c;
  assign lf_s   = $signed({{(KW-LW){1'b0}}, lf_r});
  assign lh_s   = $signed({{(KW-LW){1'b0}}, lh_r});
  assign q_s    = div_res[KW-1:0];
  assign lf6    = (lf_s <<< 2) + (lf_s <<< 1);
  assign lf20   = (lf_s <<< 4) + (lf_s <<< 2);
  assign lh10   = (lh_s <<< 3) + (lh_s <<< 1);
  assign lh20   = lh10 <<< 1;
  assign lh_att = $signed({{(KW-24){1'b0}}, lh_q10});

  always_comb begin
    unique case (mode_r)
      msui_pkg::MODE_ATT: p_c = lf6 - msui_pkg::PLF_OFS + msui_pkg::ATT_OFS - lh_att;
      msui_pkg::MODE_OKU: begin
        if (hr_eff <= msui_pkg::OKU_HR_SPLIT) begin
          p_c = lf6 - msui_pkg::PLF_OFS + msui_pkg::OKU_LO_OFS - lh10;
        end else begin
          p_c = lf6 - msui_pkg::PLF_OFS + msui_pkg::OKU_HI_OFS - lh20;
        end
      end
      default: p_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.lg_load) begin
      lg_n_r    <= lg_n0;
      lg_m_r    <= msui_pkg::lg_norm(lg_x, lg_n0);
      lg_frac_r <= '0;
    end else if (ctl.lg_step) begin
      lg_m_r    <= lg_sq[MW-1:0];
      lg_frac_r <= {lg_frac_r[FW-2:0], lg_sq[MW]};
    end

    if (ctl.div_load) begin
      dq_r   <= div_num[DW] ? div_neg_num[DW-1:0] : div_num[DW-1:0];
      drem_r <= '0;
      dden_r <= div_den;
      dneg_r <= div_num[DW];
    end else if (ctl.div_step) begin
      dq_r   <= {dq_r[DW-2:0], div_ge};
      drem_r <= div_ge ? div_sub[DNW-1:0] : div_t[DNW-1:0];
    end

    unique case (state_r)
      msui_pkg::ES_LF_MUL: lf_r  <= lg10_c;
      msui_pkg::ES_LH_MUL: lh_r  <= lg10_c;
      msui_pkg::ES_HT2:    ht2_r <= ht_eff * ht_eff;
      msui_pkg::ES_NUM1:   num_r <= $signed({10'b0, num1});
      msui_pkg::ES_NUM2:   num_r <= num_r - $signed({13'b0, b_ht2});
      msui_pkg::ES_GAMMA:  gamma_r <= (div_res <= 0) ? GW'(1) : div_res[GW-1:0];
      msui_pkg::ES_P:      p_r <= p_c[PW-1:0];
      msui_pkg::ES_FIN: begin
        g10_r <= {1'b0, gamma_r, 3'b0} + {3'b0, gamma_r, 1'b0};
        kb_r  <= lf20 + msui_pkg::FS_D0_OFS - q_s + KW'(p_r);
        kf_r  <= lf20 - msui_pkg::FS_CONST;
      end
      default: ;
    endcase
  end

  assign coef.ok  = ctl.ok;
  assign coef.g10 = g10_r;
  assign coef.p   = p_r;
  assign coef.kb  = kb_r;
  assign coef.kf  = kf_r;

endmodule

FILE: rtl/core/modified_sui_path_loss.sv
`timescale 1ns / 1ps
// Erceg/SUI path loss: 21-stage item pipeline plus a coefficient engine.
// Results pass through 21 register stages; one item per cycle while the output is not stalled.
// The log2 of the distance takes 16 squaring stages, one multiplier each.
// After reset and after every config write the coefficient engine recomputes the coefficients
// (two serial logs and two 48-step divisions); in_ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module modified_sui_path_loss (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [msui_pkg::DIST_W-1:0]            in_distance_dm,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [msui_pkg::LOSS_W-1:0]     out_path_loss_q8,
  output logic                                   out_beyond_breakpoint,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [msui_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [msui_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int NSQ = msui_pkg::NSQ;
  localparam int NST = msui_pkg::NST;
  localparam int MW  = msui_pkg::MANT_W;
  localparam int FW  = msui_pkg::FRAC_W;
  localparam int NW  = msui_pkg::MSB_W;
  localparam int LW  = msui_pkg::LG_W;
  localparam int DW  = msui_pkg::DIST_W;
  localparam int GW  = msui_pkg::G10_W;
  localparam int PW  = msui_pkg::P_W;
  localparam int KW  = msui_pkg::K_W;
  localparam int TPW = GW + 1 + LW + 1;  // signed product of 10*gamma and the log term
  localparam int SW  = TPW - 16 + 1;     // loss sum width
  localparam int QW  = SW + 1 - 8;       // width after rounding to Q8

  // Coefficients that depend only on the registers (gamma, corrections, offsets)
  // come from a sequential engine; the item path is a pure pipeline.
  msui_pkg::coef_t coef;

  assign cfg_ready = 1'b1;

  msui_coef_eng u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Global advance: the whole pipe moves unless the output register is full and stalled.
  logic           adv;
  logic           in_acc;
  logic [NST-1:0] vld_r;

  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv && coef.ok;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_acc};
    end
  end

  // Stage 0: zero distance reads as 1 dm, then normalize to a Q30 mantissa.
  logic [DW-1:0] d_eff;
  logic [NW-1:0] n0;
  assign d_eff = (in_distance_dm == '0) ? DW'(1) : in_distance_dm;
  assign n0    = msui_pkg::msb_idx(d_eff);

  logic [MW-1:0] m_r    [0:NSQ];
  logic [NW-1:0] n_r    [0:NSQ];
  logic [FW-1:0] frac_r [1:NSQ];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= msui_pkg::lg_norm(d_eff, n0);
      n_r[0] <= n0;
    end
  end

  // Stages 1..16: one fraction bit of log2 per stage by squaring the mantissa.
  for (genvar k = 1; k <= NSQ; k++) begin : g_sq
    logic [MW:0] sq;
    assign sq = msui_pkg::sq_step(m_r[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[k] <= sq[MW-1:0];
        n_r[k] <= n_r[k-1];
      end
    end
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) frac_r[k] <= {{(FW-1){1'b0}}, sq[MW]};
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) frac_r[k] <= {frac_r[k-1][FW-2:0], sq[MW]};
      end
    end
  end

  // Stage 17: log10 = log2 * log10(2), Q16.
  logic [LW-1:0] lg_r;
  always_ff @(posedge clk) begin
    if (adv) lg_r <= msui_pkg::lg10_q16(n_r[NSQ], frac_r[NSQ]);
  end

  // Stage 18: 10*gamma*(log10(d) - log10(100 m)) and the free-space 20*log10(d).
  logic signed [LW:0]    lterm;
  logic signed [TPW-1:0] tprod_c, tprod_r;
  logic [LW+4:0]         fs_c, fs_r;

  assign lterm   = $signed({1'b0, lg_r}) - msui_pkg::D0_LOG;
  assign tprod_c = $signed({1'b0, coef.g10}) * lterm;
  assign fs_c    = {1'b0, lg_r, 4'b0} + {3'b0, lg_r, 2'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      tprod_r <= tprod_c;
      fs_r    <= fs_c;
    end
  end

  // Stage 19: floor the slope term, pick breakpoint side, form the Q16 loss.
  logic signed [SW-1:0] tterm, p_e, kb_e, kf_e, fs_e, sum_tp, loss_c, loss_r;
  logic                 beyond_c, beyond_r;

  assign tterm    = $signed({tprod_r[TPW-1], tprod_r[TPW-1:16]});
  assign p_e      = $signed({{(SW-PW){coef.p[PW-1]}}, coef.p});
  assign kb_e     = $signed({{(SW-KW){coef.kb[KW-1]}}, coef.kb});
  assign kf_e     = $signed({{(SW-KW){coef.kf[KW-1]}}, coef.kf});
  assign fs_e     = $signed({{(SW-LW-5){1'b0}}, fs_r});
  assign sum_tp   = tterm + p_e;
  assign beyond_c = (sum_tp > 0);
  assign loss_c   = beyond_c ? (tterm + kb_e) : (fs_e + kf_e);

  always_ff @(posedge clk) begin
    if (adv) begin
      loss_r   <= loss_c;
      beyond_r <= beyond_c;
    end
  end

  // Stage 20: round to Q8 (floor of v+128 over 256) and saturate to 17 bits.
  logic signed [SW:0]   rnd;
  logic signed [QW-1:0] q8;
  logic signed [QW-1:0] q_max, q_min;

  assign rnd   = {loss_r[SW-1], loss_r} + (SW+1)'(128);
  assign q8    = rnd[SW:8];
  assign q_max = QW'(65535);
  assign q_min = -QW'(65536);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beyond_breakpoint <= beyond_r;
      if (q8 > q_max) begin
        out_path_loss_q8 <= q_max[msui_pkg::LOSS_W-1:0];
      end else if (q8 < q_min) begin
        out_path_loss_q8 <= q_min[msui_pkg::LOSS_W-1:0];
      end else begin
        out_path_loss_q8 <= q8[msui_pkg::LOSS_W-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input accepted while coefficients are being recomputed");

  a_gamma_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    coef.ok |-> coef.g10 != '0)
    else $error("coefficients ready with zero path loss exponent");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during an output stall");
`endif

endmodule
